FILE: rtl/itrt_pkg.sv
// shared constants, types and the digit-to-ascii function for the radix text converter
`timescale 1ns / 1ps
`default_nettype none

package itrt_pkg;

	localparam int WORD_WIDTH     = 32;
	localparam int VALUE_W        = 32;
	localparam int RADIX_W        = 6;
	localparam int DIGIT_W        = 6;
	localparam int CHAR_W         = 7;
	localparam int ADDR_W         = $clog2(WORD_WIDTH);
	localparam int CNT_W          = $clog2(WORD_WIDTH + 1);
	localparam int BITS_PER_CYCLE = 4;
	localparam int DIV_STEPS      = (WORD_WIDTH + BITS_PER_CYCLE - 1) / BITS_PER_CYCLE;
	localparam int DIV_W          = DIV_STEPS * BITS_PER_CYCLE;
	localparam int STEP_CNT_W     = $clog2(DIV_STEPS);

	localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
	localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);
	localparam logic [DIGIT_W-1:0] DIGIT_MAX = DIGIT_W'(35);
	localparam logic [DIGIT_W-1:0] DIGIT_TEN = DIGIT_W'(10);

	localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2d;
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
	localparam logic [CHAR_W-1:0] CHAR_LOW_A = 7'h61;

	typedef struct packed {
		logic               done;
		logic [DIGIT_W-1:0] remainder;
		logic [DIV_W-1:0]   quotient;
	} div_res_t;

	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
		logic [DIGIT_W-1:0] dc;
		dc = (d > DIGIT_MAX) ? DIGIT_MAX : d;
		if (dc < DIGIT_TEN) begin
			return CHAR_ZERO + CHAR_W'(dc);
		end
		return CHAR_LOW_A + CHAR_W'(dc - DIGIT_TEN);
	endfunction

endpackage

`default_nettype wire

FILE: rtl/itrt_digit_ram.sv
// digit store: one write port, one read port with registered read data
`timescale 1ns / 1ps
`default_nettype none

module itrt_digit_ram (
	input  wire logic                         clk,
	input  wire logic                         we,
	input  wire logic [itrt_pkg::ADDR_W-1:0]  waddr,
	input  wire logic [itrt_pkg::DIGIT_W-1:0] wdata,
	input  wire logic                         re,
	input  wire logic [itrt_pkg::ADDR_W-1:0]  raddr,
	output logic      [itrt_pkg::DIGIT_W-1:0] rdata
);

	logic [itrt_pkg::DIGIT_W-1:0] mem_q [itrt_pkg::WORD_WIDTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/itrt_divider.sv
// iterative divider: magnitude by radix, four quotient bits per cycle
`timescale 1ns / 1ps
`default_nettype none

module itrt_divider (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         go,
	input  wire logic [itrt_pkg::DIV_W-1:0]   dividend,
	input  wire logic [itrt_pkg::RADIX_W-1:0] divisor,
	output itrt_pkg::div_res_t                res
);

	logic                            busy_q;
	logic                            done_q;
	logic [itrt_pkg::STEP_CNT_W-1:0] cnt_q;
	logic [itrt_pkg::DIV_W-1:0]      quo_q;
	logic [itrt_pkg::DIGIT_W-1:0]    rem_q;
	logic [itrt_pkg::RADIX_W-1:0]    div_q;
	logic [itrt_pkg::DIV_W-1:0]      quo_n;
	logic [itrt_pkg::DIGIT_W-1:0]    rem_n;

	// restoring division; dividend bits shift out at the top, quotient bits in at the bottom
	always_comb begin
		logic [itrt_pkg::DIGIT_W:0] trial;
		quo_n = quo_q;
		rem_n = rem_q;
		for (int i = 0; i < itrt_pkg::BITS_PER_CYCLE; i++) begin
			trial = {rem_n, quo_n[itrt_pkg::DIV_W-1]};
			quo_n = {quo_n[itrt_pkg::DIV_W-2:0], 1'b0};
			if (trial >= {1'b0, div_q}) begin
				trial    = trial - {1'b0, div_q};
				quo_n[0] = 1'b1;
			end
			rem_n = trial[itrt_pkg::DIGIT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == itrt_pkg::STEP_CNT_W'(itrt_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= quo_n;
			rem_q <= rem_n;
		end
	end

	assign res.done      = done_q;
	assign res.remainder = rem_q;
	assign res.quotient  = quo_q;

endmodule

`default_nettype wire

FILE: rtl/integer_to_radix_text.sv
// integer to radix text converter: top level with sequencer
//
// request channel: value (signed 32 bit) and radix (2..36, saturated outside
// that range) are taken at a rising edge where start is high and busy is low.
// busy stays high until the last character of the request has been shown.
// result channel: one ascii character per cycle on character, marked by
// strobe; last is high with the final character. the receiver cannot stall,
// so every strobed character is taken in the cycle it appears.
// the magnitude is divided by the radix repeatedly in a shared divider that
// resolves four quotient bits per cycle; each remainder is written into the
// digit memory, least significant first.
// the digits are then read back most significant first, one per cycle, with
// registered read data; a leading '-' goes out first for a negative value.
// a new request can be taken in the first cycle that busy is low.
// reset clears the sequencer and the digit count; the digit memory is not
// cleared since every entry is written before it is read.
`timescale 1ns / 1ps
`default_nettype none

module integer_to_radix_text (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic signed [itrt_pkg::VALUE_W-1:0] value,
	input  wire logic        [itrt_pkg::RADIX_W-1:0] radix,
	output logic                                     strobe,
	output logic             [itrt_pkg::CHAR_W-1:0]  character,
	output logic                                     last
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_DIV   = 2'd1;
	localparam logic [1:0] ST_EMIT  = 2'd2;
	localparam logic [1:0] ST_DRAIN = 2'd3;

	logic [1:0]                        state_q;
	logic [itrt_pkg::CNT_W-1:0]        cnt_q;
	logic [itrt_pkg::ADDR_W-1:0]       rd_addr_q;
	logic                              neg_q;
	logic                              sign_pend_q;
	logic [itrt_pkg::RADIX_W-1:0]      radix_q;
	logic                              rd_vld_s1;
	logic                              rd_last_s1;

	logic                              accept;
	logic [itrt_pkg::WORD_WIDTH-1:0]   word;
	logic                              neg;
	logic [itrt_pkg::WORD_WIDTH-1:0]   mag;
	logic [itrt_pkg::RADIX_W-1:0]      radix_sat;
	logic                              finish;
	logic                              div_go;
	logic [itrt_pkg::DIV_W-1:0]        dividend;
	logic [itrt_pkg::RADIX_W-1:0]      divisor;
	logic                              wr_en;
	logic                              rd_en;
	logic [itrt_pkg::DIGIT_W-1:0]      rd_digit;
	itrt_pkg::div_res_t                div_res;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	assign word = value[itrt_pkg::WORD_WIDTH-1:0];
	assign neg  = word[itrt_pkg::WORD_WIDTH-1];
	assign mag  = neg ? (~word + 1'b1) : word;

	always_comb begin
		priority if (radix < itrt_pkg::RADIX_MIN) begin
			radix_sat = itrt_pkg::RADIX_MIN;
		end else if (radix > itrt_pkg::RADIX_MAX) begin
			radix_sat = itrt_pkg::RADIX_MAX;
		end else begin
			radix_sat = radix;
		end
	end

	// conversion ends when the quotient is zero or the store is full
	assign finish = (div_res.quotient == '0)
		|| (cnt_q == itrt_pkg::CNT_W'(itrt_pkg::WORD_WIDTH - 1));

	assign wr_en    = (state_q == ST_DIV) && div_res.done;
	assign div_go   = accept || (wr_en && !finish);
	assign dividend = (state_q == ST_IDLE) ? itrt_pkg::DIV_W'(mag) : div_res.quotient;
	assign divisor  = (state_q == ST_IDLE) ? radix_sat : radix_q;
	assign rd_en    = (state_q == ST_EMIT);

	itrt_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.dividend (dividend),
		.divisor  (divisor),
		.res      (div_res)
	);

	itrt_digit_ram u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (cnt_q[itrt_pkg::ADDR_W-1:0]),
		.wdata (div_res.remainder),
		.re    (rd_en),
		.raddr (rd_addr_q),
		.rdata (rd_digit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			neg_q       <= 1'b0;
			sign_pend_q <= 1'b0;
			rd_vld_s1   <= 1'b0;
		end else begin
			rd_vld_s1 <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						neg_q   <= neg;
						cnt_q   <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_res.done) begin
						cnt_q <= cnt_q + 1'b1;
						if (finish) begin
							sign_pend_q <= neg_q;
							state_q     <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					sign_pend_q <= 1'b0;
					rd_vld_s1   <= 1'b1;
					if (rd_addr_q == '0) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			radix_q <= radix_sat;
		end
		if (wr_en) begin
			rd_addr_q <= cnt_q[itrt_pkg::ADDR_W-1:0];
		end else if (rd_en && rd_addr_q != '0) begin
			rd_addr_q <= rd_addr_q - 1'b1;
		end
		if (rd_en) begin
			rd_last_s1 <= (rd_addr_q == '0);
		end
	end

	// the sign goes out in the first read cycle, before any digit data is back
	assign strobe    = rd_vld_s1 || (rd_en && sign_pend_q);
	assign character = rd_vld_s1 ? itrt_pkg::digit_char(rd_digit) : itrt_pkg::CHAR_MINUS;
	assign last      = rd_vld_s1 && rd_last_s1;

endmodule

`default_nettype wire
